// ===== rtl/core/vpdi_pkg.sv =====
package vpdi_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int FIELD_W     = 16;
   localparam int IDX_W       = 10;
   localparam int UCNT_W      = 11;

   typedef struct packed {
      logic [FIELD_W-1:0] vertex_index;
      logic [FIELD_W-1:0] texcoord_index;
      logic [FIELD_W-1:0] tex_s;
      logic [FIELD_W-1:0] tex_t;
   } corner_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      corner_type        data;
   } wr_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ===== rtl/core/vpdi_table.sv =====
module vpdi_table
   import vpdi_pkg::*;
(
   input  logic              clock,
   input  wr_type            wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output corner_type        rd_data
);

   corner_type mem [TABLE_DEPTH];
   corner_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/vpdi_cmp.sv =====
module vpdi_cmp
   import vpdi_pkg::*;
(
   input  corner_type entry,
   input  corner_type key,
   output logic       match
);

   logic same_vertex;
   logic same_texidx;
   logic same_st;

   always_comb begin
      same_vertex = entry.vertex_index == key.vertex_index;
      same_texidx = entry.texcoord_index == key.texcoord_index;
      same_st     = (entry.tex_s == key.tex_s) && (entry.tex_t == key.tex_t);
      match       = same_vertex && (same_texidx || same_st);
   end

endmodule

// ===== rtl/core/vertex_pair_dedup_indexer.sv =====
// Unique-corner indexer. Raise start with a corner while busy is low; the block
// scans its table of unique corners one entry per cycle through a single read
// port and one shared comparator. The scan stops at the first matching entry,
// or after all N stored entries (at most 1024) when none matches. The result
// appears on the rsp_ ports with rsp_valid high for exactly one cycle, in the
// cycle busy drops; the receiver cannot stall it, so capture it then. A corner
// with last_corner set empties the table once its result is formed.
module vertex_pair_dedup_indexer
   import vpdi_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FIELD_W-1:0]  req_vertex_index,
   input  logic [FIELD_W-1:0]  req_texcoord_index,
   input  logic signed [FIELD_W-1:0] req_tex_s,
   input  logic signed [FIELD_W-1:0] req_tex_t,
   input  logic                req_last_corner,
   output logic                rsp_valid,
   output logic [IDX_W-1:0]    rsp_unique_index,
   output logic                rsp_was_added,
   output logic                rsp_overflow,
   output logic [UCNT_W-1:0]   rsp_unique_count
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [ADDR_W-1:0] chk_idx_ff, chk_idx_in;
   corner_type        key_ff, key_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_added_ff, rsp_added_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic [UCNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic              accept;
   logic              match;
   logic              hit;
   logic              finish;
   logic              full;
   logic              append;
   logic [ADDR_W-1:0] res_idx;
   logic [CNT_W-1:0]  new_count;
   corner_type        rd_data;
   wr_type            wr;

   vpdi_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   vpdi_cmp u_cmp (
      .entry (rd_data),
      .key   (key_ff),
      .match (match)
   );

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      hit       = (state_ff == ST_SCAN) && chk_valid_ff && match;
      finish    = (state_ff == ST_SCAN) && (hit || (addr_ff == count_ff));
      full      = count_ff == CNT_W'(TABLE_DEPTH);
      append    = finish && !hit && !full;
      new_count = count_ff + CNT_W'(append);

      if (hit) begin
         res_idx = chk_idx_ff;
      end else if (append) begin
         res_idx = count_ff[ADDR_W-1:0];
      end else begin
         res_idx = '0;
      end

      key_in       = key_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      count_in     = count_ff;

      if (accept) begin
         key_in.vertex_index   = req_vertex_index;
         key_in.texcoord_index = req_texcoord_index;
         key_in.tex_s          = $unsigned(req_tex_s);
         key_in.tex_t          = $unsigned(req_tex_t);
         last_in               = req_last_corner;
         addr_in               = '0;
      end else if ((state_ff == ST_SCAN) && !finish) begin
         addr_in      = addr_ff + CNT_W'(1);
         chk_valid_in = 1'b1;
         chk_idx_in   = addr_ff[ADDR_W-1:0];
      end

      if (finish) begin
         count_in = last_ff ? '0 : new_count;
      end

      wr.en   = append;
      wr.addr = count_ff[ADDR_W-1:0];
      wr.data = key_ff;

      rsp_valid_in = finish;
      rsp_index_in = finish ? IDX_W'(res_idx) : rsp_index_ff;
      rsp_added_in = finish ? append : rsp_added_ff;
      rsp_ovf_in   = finish ? (!hit && full) : rsp_ovf_ff;
      rsp_count_in = finish ? UCNT_W'(new_count) : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      last_ff      <= last_in;
      addr_ff      <= addr_in;
      chk_idx_ff   <= chk_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_added_ff <= rsp_added_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_unique_index = rsp_index_ff;
   assign rsp_was_added    = rsp_added_ff;
   assign rsp_overflow     = rsp_ovf_ff;
   assign rsp_unique_count = rsp_count_ff;

endmodule

// ===== tb/vertex_pair_dedup_indexer_test.sv =====
module vertex_pair_dedup_indexer_test;
   import vpdi_pkg::*;

   localparam int CLOCK_HALF   = 6;
   localparam int STALL_LIMIT  = 12000;
   localparam int SETTLE_TICKS = TABLE_DEPTH + 80;

   typedef struct packed {
      logic [IDX_W-1:0]  unique_index;
      logic              was_added;
      logic              overflow;
      logic [UCNT_W-1:0] unique_count;
   } dedup_result_type;

   class unique_corner_board;
      logic [FIELD_W-1:0] pos_tbl [TABLE_DEPTH];
      logic [FIELD_W-1:0] tidx_tbl [TABLE_DEPTH];
      logic [FIELD_W-1:0] s_tbl [TABLE_DEPTH];
      logic [FIELD_W-1:0] t_tbl [TABLE_DEPTH];
      int unsigned entries;
      dedup_result_type expected_indices[$];
      int errors;
      int corners_seen;
      int added_seen;
      int matched_seen;
      int overflow_seen;

      function new();
         entries = 0;
         errors = 0;
         corners_seen = 0;
         added_seen = 0;
         matched_seen = 0;
         overflow_seen = 0;
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function int pending();
         return expected_indices.size();
      endfunction

      function void note_corner(input logic [FIELD_W-1:0] v, input logic [FIELD_W-1:0] st,
                                input logic [FIELD_W-1:0] s, input logic [FIELD_W-1:0] t,
                                input logic last);
         dedup_result_type r;
         bit hit;
         r = '0;
         hit = 0;
         for (int k = 0; k < entries; k++) begin
            if (!hit && pos_tbl[k] == v &&
                (tidx_tbl[k] == st || (s_tbl[k] == s && t_tbl[k] == t))) begin
               hit = 1;
               r.unique_index = IDX_W'(k);
            end
         end
         if (hit) begin
            matched_seen++;
         end else if (entries < TABLE_DEPTH) begin
            pos_tbl[entries]  = v;
            tidx_tbl[entries] = st;
            s_tbl[entries]    = s;
            t_tbl[entries]    = t;
            r.unique_index = IDX_W'(entries);
            r.was_added = 1'b1;
            entries++;
            added_seen++;
         end else begin
            r.overflow = 1'b1;
            overflow_seen++;
         end
         r.unique_count = UCNT_W'(entries);
         if (last) begin
            entries = 0;
         end
         corners_seen++;
         expected_indices.push_back(r);
      endfunction

      task check_result(input dedup_result_type got);
         dedup_result_type want;
         if (expected_indices.size() == 0) begin
            report($sformatf("result with no corner waiting, index %0d", got.unique_index));
            return;
         end
         want = expected_indices.pop_front();
         if (got.unique_index !== want.unique_index) begin
            report($sformatf("unique_index %0d, want %0d", got.unique_index,
                             want.unique_index));
         end
         if (got.was_added !== want.was_added) begin
            report($sformatf("was_added %0b, want %0b", got.was_added, want.was_added));
         end
         if (got.overflow !== want.overflow) begin
            report($sformatf("overflow %0b, want %0b", got.overflow, want.overflow));
         end
         if (got.unique_count !== want.unique_count) begin
            report($sformatf("unique_count %0d, want %0d", got.unique_count,
                             want.unique_count));
         end
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [FIELD_W-1:0]        req_vertex_index = '0;
   logic [FIELD_W-1:0]        req_texcoord_index = '0;
   logic signed [FIELD_W-1:0] req_tex_s = '0;
   logic signed [FIELD_W-1:0] req_tex_t = '0;
   logic                      req_last_corner = 1'b0;
   logic                      rsp_valid;
   logic [IDX_W-1:0]          rsp_unique_index;
   logic                      rsp_was_added;
   logic                      rsp_overflow;
   logic [UCNT_W-1:0]         rsp_unique_count;

   unique_corner_board board = new();
   dedup_result_type   seen_result;
   int                 stall_cycles = 0;
   int                 models_played = 0;

   vertex_pair_dedup_indexer i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_vertex_index   (req_vertex_index),
      .req_texcoord_index (req_texcoord_index),
      .req_tex_s          (req_tex_s),
      .req_tex_t          (req_tex_t),
      .req_last_corner    (req_last_corner),
      .rsp_valid          (rsp_valid),
      .rsp_unique_index   (rsp_unique_index),
      .rsp_was_added      (rsp_was_added),
      .rsp_overflow       (rsp_overflow),
      .rsp_unique_count   (rsp_unique_count)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            seen_result.unique_index = rsp_unique_index;
            seen_result.was_added    = rsp_was_added;
            seen_result.overflow     = rsp_overflow;
            seen_result.unique_count = rsp_unique_count;
            board.check_result(seen_result);
         end
         if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_corner(input logic [FIELD_W-1:0] v, input logic [FIELD_W-1:0] st,
                              input logic [FIELD_W-1:0] s, input logic [FIELD_W-1:0] t,
                              input logic last, input int idle_pct);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         gap++;
      end
      @(negedge clock);
      start              <= 1'b1;
      req_vertex_index   <= v;
      req_texcoord_index <= st;
      req_tex_s          <= s;
      req_tex_t          <= t;
      req_last_corner    <= last;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      board.note_corner(v, st, s, t, last);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic fill_table();
      logic [FIELD_W-1:0] st_top;
      logic [FIELD_W-1:0] s_top;
      logic [FIELD_W-1:0] t_top;
      st_top = '0;
      s_top = '0;
      t_top = '0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         st_top = FIELD_W'($urandom);
         s_top  = FIELD_W'($urandom);
         t_top  = FIELD_W'($urandom);
         send_corner(FIELD_W'(k), st_top, s_top, t_top, 1'b0, 0);
      end
      // hit the newest entry by texcoord index and by s/t, miss on a full table, then empty it
      send_corner(FIELD_W'(TABLE_DEPTH - 1), st_top, 16'h0, 16'h0, 1'b0, 0);
      send_corner(FIELD_W'(TABLE_DEPTH - 1), 16'h0, s_top, t_top, 1'b0, 0);
      send_corner(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b0, 0);
      send_corner(16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 0);
      send_corner(16'hFFFF, FIELD_W'($urandom), 16'h0, 16'hFFFF, 1'b1, 0);
      send_corner(16'hFFFF, 16'h0, 16'h0, 16'h0, 1'b0, 0);
      send_corner(16'hFFFF, 16'h1, 16'h1, 16'h1, 1'b1, 0);
   endtask

   task automatic play_models(input int n_items, input int idle_pct);
      logic [FIELD_W-1:0] pos_pool [8];
      logic [FIELD_W-1:0] tidx_pool [8];
      logic [FIELD_W-1:0] s_pool [8];
      logic [FIELD_W-1:0] t_pool [8];
      logic [FIELD_W-1:0] v;
      logic [FIELD_W-1:0] st;
      logic [FIELD_W-1:0] s;
      logic [FIELD_W-1:0] t;
      logic last;
      int left;
      int len;
      int n_pos;
      int n_tex;
      int pick;
      int roll;
      left = n_items;
      while (left > 0) begin
         len = $urandom_range(40, 3);
         if (len > left) begin
            len = left;
         end
         n_pos = $urandom_range(8, 1);
         n_tex = $urandom_range(8, 1);
         for (int j = 0; j < 8; j++) begin
            pos_pool[j]  = FIELD_W'($urandom);
            tidx_pool[j] = FIELD_W'($urandom);
            s_pool[j]    = FIELD_W'($urandom);
            t_pool[j]    = FIELD_W'($urandom);
            if (j > 0 && $urandom_range(99) < 30) begin
               s_pool[j] = s_pool[0];
               t_pool[j] = t_pool[0];
            end
         end
         for (int j = 0; j < len; j++) begin
            pick = $urandom_range(n_tex - 1);
            v    = pos_pool[$urandom_range(n_pos - 1)];
            st   = tidx_pool[pick];
            s    = s_pool[pick];
            t    = t_pool[pick];
            roll = $urandom_range(99);
            if (roll < 8) begin
               v  = FIELD_W'($urandom);
               st = FIELD_W'($urandom);
               s  = FIELD_W'($urandom);
               t  = FIELD_W'($urandom);
            end else if (roll < 14) begin
               s = FIELD_W'($urandom);
               t = FIELD_W'($urandom);
            end else if (roll < 18) begin
               st = FIELD_W'($urandom);
            end
            last = (j == len - 1) || ($urandom_range(99) < 3);
            send_corner(v, st, s, t, last, idle_pct);
         end
         left -= len;
         models_played++;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_corner(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
      send_corner(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
      send_corner(16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0, 0);
      send_corner(16'h0000, 16'h0000, 16'h0005, 16'h0005, 1'b0, 0);
      send_corner(16'h0000, 16'h0002, 16'h0001, 16'h0000, 1'b0, 0);
      send_corner(16'h0000, 16'h0003, 16'h0000, 16'h0001, 1'b0, 0);
      send_corner(16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
      send_corner(16'h0000, 16'h0002, 16'h0000, 16'h0000, 1'b0, 0);
      send_corner(16'h0000, 16'h0003, 16'h0001, 16'h0000, 1'b0, 0);
      send_corner(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b0, 0);
      send_corner(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 1'b0, 0);
      send_corner(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b0, 0);
      send_corner(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 1'b0, 0);
      send_corner(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
      send_corner(16'h8000, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b0, 0);
      send_corner(16'h1234, 16'h5678, 16'h0001, 16'hFFFF, 1'b1, 0);
      send_corner(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
      send_corner(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 0);
      send_corner(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 0);
      send_corner(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 0);
      send_corner(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1, 0);
      drain_results();

      fill_table();
      drain_results();

      play_models(200, 0);
      drain_results();
      play_models(190, 65);
      play_models(190, 22);

      drain_results();
      repeat (SETTLE_TICKS) @(negedge clock);
      if (board.pending() != 0) begin
         board.report($sformatf("%0d results never arrived", board.pending()));
      end
      $display("%0d corners in %0d random models plus directed and full-table runs",
               board.corners_seen, models_played);
      $display("%0d appended, %0d matched, %0d overflowed; sender idle 0, 22 and 65 pct",
               board.added_seen, board.matched_seen, board.overflow_seen);
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
